// ===== src/thermal_false_color_map_defines.svh =====
// ---------------------------------------------------------------------------
// thermal_false_color_map_defines.svh
// Assertion macros shared by the false-color map RTL.
// ---------------------------------------------------------------------------
// Both macros assume signals named clk and rst_n in the calling module.
`ifndef THERMAL_FALSE_COLOR_MAP_DEFINES_SVH
`define THERMAL_FALSE_COLOR_MAP_DEFINES_SVH

`ifndef SYNTHESIS
// condition must hold on every clock edge outside reset
`define TFCM_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("tfcm: invariant violated");
// pre implies post in the same cycle
`define TFCM_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("tfcm: implication violated");
`else
`define TFCM_ASSERT(label, cond)
`define TFCM_ASSERT_IMP(label, pre, post)
`endif

`endif

// ===== src/tfcm_pkg.sv =====
// ---------------------------------------------------------------------------
// tfcm_pkg
// Types, codes and elaboration-time threshold math for the false-color map.
// ---------------------------------------------------------------------------
package tfcm_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int TEMP_W            = 16;
  localparam int PIXEL_W           = 16;
  localparam int ALPHA_W           = 4;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 16;
  localparam int NUM_LEVELS        = 15;

  typedef logic [1:0]          clip_t;
  typedef logic [1:0]          quarter_t;
  typedef logic [3:0]          nibble_t;
  typedef logic [TEMP_W-1:0]   temp_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LEVEL = 2'd2;

  // clip status codes
  localparam clip_t CLIP_NONE     = 2'd0;
  localparam clip_t CLIP_LOW      = 2'd1;
  localparam clip_t CLIP_HIGH     = 2'd2;
  localparam clip_t CLIP_RESERVED = 2'd3;

  // quarters of the color scale
  localparam quarter_t QTR_BLUE_GREEN = 2'd0;
  localparam quarter_t QTR_GREEN_BLUE = 2'd1;
  localparam quarter_t QTR_GREEN_RED  = 2'd2;
  localparam quarter_t QTR_RED_GREEN  = 2'd3;

  localparam nibble_t LEVEL_FULL = 4'hF;
  localparam nibble_t LEVEL_ZERO = 4'h0;

  // reset values
  localparam temp_t              LOW_LIMIT_RST   = 16'hFE70; // -400
  localparam temp_t              HIGH_LIMIT_RST  = 16'h04B0; // 1200
  localparam logic [ALPHA_W-1:0] ALPHA_LEVEL_RST = 4'd8;

  localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C235;
  localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;

  // ---- elaboration-time helpers: used only to build constant thresholds ----

  // (a*b) >> s, low 64 bits
  function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                            input int s);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    prod = prod >> s;
    return prod[63:0];
  endfunction

  // sin(x), x in [0, pi/2], Q62
  function automatic logic [63:0] sin_q62(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = mul_shift(x, x, 62);
    term = x;
    sum  = x;
    term = mul_shift(term, x2, 62) / 64'd6;   sum = sum - term;
    term = mul_shift(term, x2, 62) / 64'd20;  sum = sum + term;
    term = mul_shift(term, x2, 62) / 64'd42;  sum = sum - term;
    term = mul_shift(term, x2, 62) / 64'd72;  sum = sum + term;
    term = mul_shift(term, x2, 62) / 64'd110; sum = sum - term;
    term = mul_shift(term, x2, 62) / 64'd156; sum = sum + term;
    term = mul_shift(term, x2, 62) / 64'd210; sum = sum - term;
    term = mul_shift(term, x2, 62) / 64'd272; sum = sum + term;
    term = mul_shift(term, x2, 62) / 64'd342; sum = sum - term;
    term = mul_shift(term, x2, 62) / 64'd420; sum = sum + term;
    term = mul_shift(term, x2, 62) / 64'd506; sum = sum - term;
    term = mul_shift(term, x2, 62) / 64'd600; sum = sum + term;
    term = mul_shift(term, x2, 62) / 64'd702; sum = sum - term;
    return sum;
  endfunction

  // level 0..15 for ramp position q in [0, Q], Q = 2^(fb-2)
  function automatic logic [3:0] ramp_level(input logic [63:0] q, input int fb);
    logic [63:0] qf;
    logic [63:0] d;
    logic [63:0] x;
    logic [63:0] s;
    logic [63:0] a;
    logic        pos;
    qf = 64'd1 << (fb - 2);
    if (q == 64'd0) begin
      return LEVEL_ZERO;
    end
    if (q >= qf) begin
      return LEVEL_FULL;
    end
    pos = ((q << 1) > qf);
    d   = pos ? (q << 1) - qf : qf - (q << 1);
    x   = mul_shift(PI_Q62, d, fb - 1);
    s   = sin_q62(x);
    if (s > ONE_Q62) begin
      s = ONE_Q62;
    end
    s = s >> 4;
    a = 64'd15 << 58;
    if (pos) begin
      a = a + 64'd15 * s;
    end else begin
      a = a - 64'd15 * s;
    end
    a = a >> 59;
    return (a > 64'd15) ? LEVEL_FULL : a[3:0];
  endfunction

  // smallest q whose level reaches k (k in 1..15), by bisection
  function automatic logic [31:0] ramp_thresh(input int fb, input int k);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    int          i;
    lo = 64'd0;
    hi = 64'd1 << (fb - 2);
    for (i = 0; i < 64; i++) begin
      if (hi - lo > 64'd1) begin
        mid = (lo + hi) >> 1;
        if (32'(ramp_level(mid, fb)) >= k) begin
          hi = mid;
        end else begin
          lo = mid;
        end
      end
    end
    return hi[31:0];
  endfunction

endpackage

// ===== src/thermal_false_color_map.sv =====
// ---------------------------------------------------------------------------
// thermal_false_color_map
// Jet-style false-color map: signed temperature sample in, GBAR4444 pixel out.
// Pipeline: clip stage, restoring divider stages, quarter stage, threshold
// stage and output register; the result is taken at the edge that ends the
// out_valid strobe cycle. Throughput: one transaction per cycle; busy is tied
// low, the restoring divider runs one quotient bit per pipeline stage.
// Reset (rst_n, synchronous): clears all valid bits, loads register defaults.
// ---------------------------------------------------------------------------
`include "thermal_false_color_map_defines.svh"

module thermal_false_color_map #(
  parameter int FRACTION_BITS = tfcm_pkg::FRACTION_BITS_DEF  // 8..24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input transaction
  input  logic                            start,
  output logic                            busy,
  input  logic [tfcm_pkg::TEMP_W-1:0]     in_temperature,
  // result transaction (one cycle strobe, cannot be held off)
  output logic                            out_valid,
  output logic [tfcm_pkg::PIXEL_W-1:0]    out_pixel,
  output tfcm_pkg::clip_t                 out_clip_status,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [tfcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tfcm_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int TW = tfcm_pkg::TEMP_W;
  localparam int FB = FRACTION_BITS;
  localparam int QW = FRACTION_BITS - 2;   // bits of p within a quarter
  localparam int NL = tfcm_pkg::NUM_LEVELS;

  // Every stage moves forward each cycle; nothing ever stalls.
  assign busy = 1'b0;

  logic accept;
  assign accept = start & ~busy;

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  tfcm_pkg::temp_t                low_r,   low_nxt;
  tfcm_pkg::temp_t                high_r,  high_nxt;
  logic [tfcm_pkg::ALPHA_W-1:0]   alpha_r, alpha_nxt;

  always_comb begin
    low_nxt   = low_r;
    high_nxt  = high_r;
    alpha_nxt = alpha_r;
    if (cfg_we) begin
      case (cfg_index)
        tfcm_pkg::CFG_LOW_LIMIT:   low_nxt   = cfg_data[TW-1:0];
        tfcm_pkg::CFG_HIGH_LIMIT:  high_nxt  = cfg_data[TW-1:0];
        tfcm_pkg::CFG_ALPHA_LEVEL: alpha_nxt = cfg_data[tfcm_pkg::ALPHA_W-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r   <= tfcm_pkg::LOW_LIMIT_RST;
      high_r  <= tfcm_pkg::HIGH_LIMIT_RST;
      alpha_r <= tfcm_pkg::ALPHA_LEVEL_RST;
    end else begin
      low_r   <= low_nxt;
      high_r  <= high_nxt;
      alpha_r <= alpha_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 1: clip tests, numerator t-low and denominator high-low.
  // Index 0 of the divider arrays is this stage's register.
  // In range means low < t < high, so 0 < num < den <= 65535 fit 16 bits.
  // Low test wins when both limits are met; high <= low never reaches the
  // divider as an in-range item.
  // -------------------------------------------------------------------------
  logic              dv_v_r   [0:FB];
  tfcm_pkg::clip_t   dv_st_r  [0:FB];
  logic [TW-1:0]     dv_rem_r [0:FB];
  logic [TW-1:0]     dv_den_r [0:FB];
  logic [FB-1:0]     dv_quo_r [0:FB];

  tfcm_pkg::clip_t   st1_nxt;
  logic [TW:0]       num1_ext;
  logic [TW:0]       den1_ext;

  always_comb begin
    if ($signed(in_temperature) <= $signed(low_r)) begin
      st1_nxt = tfcm_pkg::CLIP_LOW;
    end else if ($signed(in_temperature) >= $signed(high_r)) begin
      st1_nxt = tfcm_pkg::CLIP_HIGH;
    end else begin
      st1_nxt = tfcm_pkg::CLIP_NONE;
    end
    num1_ext = {in_temperature[TW-1], in_temperature} - {low_r[TW-1], low_r};
    den1_ext = {high_r[TW-1], high_r} - {low_r[TW-1], low_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else begin
      dv_v_r[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    dv_st_r[0]  <= st1_nxt;
    dv_rem_r[0] <= num1_ext[TW-1:0];
    dv_den_r[0] <= den1_ext[TW-1:0];
    dv_quo_r[0] <= '0;
  end

  // -------------------------------------------------------------------------
  // Restoring divider, one quotient bit per stage: f = (num << FB) / den.
  // The remainder stays below den, so the doubled remainder needs TW+1 bits.
  // -------------------------------------------------------------------------
  for (genvar i = 0; i < FB; i++) begin : g_div
    logic [TW:0]   rem2;
    logic [TW:0]   diff;
    logic          ge;
    logic [TW-1:0] rem_nxt;
    logic [FB-1:0] quo_nxt;

    always_comb begin
      rem2    = {dv_rem_r[i], 1'b0};
      diff    = rem2 - {1'b0, dv_den_r[i]};
      ge      = (rem2 >= {1'b0, dv_den_r[i]});
      rem_nxt = ge ? diff[TW-1:0] : rem2[TW-1:0];
      quo_nxt = {dv_quo_r[i][FB-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[i+1] <= 1'b0;
      end else begin
        dv_v_r[i+1] <= dv_v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      dv_st_r[i+1]  <= dv_st_r[i];
      dv_rem_r[i+1] <= rem_nxt;
      dv_den_r[i+1] <= dv_den_r[i];
      dv_quo_r[i+1] <= quo_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // Quarter stage: top two bits of f pick the quarter; q mirrors p in the
  // odd quarters so the sin^2 ramp falls instead of rising.
  // -------------------------------------------------------------------------
  localparam logic [QW:0] Q_FULL = {1'b1, {QW{1'b0}}};

  logic               qs_v_r;
  tfcm_pkg::clip_t    qs_st_r;
  tfcm_pkg::quarter_t qs_qtr_r, qs_qtr_nxt;
  logic [QW:0]        qs_q_r,   qs_q_nxt;

  always_comb begin
    qs_qtr_nxt = dv_quo_r[FB][FB-1:FB-2];
    qs_q_nxt   = qs_qtr_nxt[0] ? (Q_FULL - {1'b0, dv_quo_r[FB][QW-1:0]})
                               : {1'b0, dv_quo_r[FB][QW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qs_v_r <= 1'b0;
    end else begin
      qs_v_r <= dv_v_r[FB];
    end
  end

  always_ff @(posedge clk) begin
    qs_st_r  <= dv_st_r[FB];
    qs_qtr_r <= qs_qtr_nxt;
    qs_q_r   <= qs_q_nxt;
  end

  // -------------------------------------------------------------------------
  // Threshold stage: level k is reached once q >= T_k. Thresholds are
  // constants worked out at elaboration from the fixed-point sine series.
  // The hit vector is a thermometer code.
  // -------------------------------------------------------------------------
  logic [NL-1:0] hit_nxt;

  for (genvar k = 1; k <= NL; k++) begin : g_thr
    localparam logic [31:0] THR_FULL = tfcm_pkg::ramp_thresh(FB, k);
    localparam logic [QW:0] THR      = THR_FULL[QW:0];
    assign hit_nxt[k-1] = (qs_q_r >= THR);
  end

  logic               hs_v_r;
  tfcm_pkg::clip_t    hs_st_r;
  tfcm_pkg::quarter_t hs_qtr_r;
  logic [NL-1:0]      hs_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_v_r <= 1'b0;
    end else begin
      hs_v_r <= qs_v_r;
    end
  end

  always_ff @(posedge clk) begin
    hs_st_r  <= qs_st_r;
    hs_qtr_r <= qs_qtr_r;
    hs_hit_r <= hit_nxt;
  end

  // -------------------------------------------------------------------------
  // Output stage: count hits into the level, place channels by quarter.
  // Pixel layout green[15:12] blue[11:8] alpha[7:4] red[3:0].
  // -------------------------------------------------------------------------
  tfcm_pkg::nibble_t level;
  tfcm_pkg::nibble_t g_ch, b_ch, r_ch;
  logic [tfcm_pkg::PIXEL_W-1:0] pixel_nxt;

  logic                         out_valid_r;
  logic [tfcm_pkg::PIXEL_W-1:0] out_pixel_r;
  tfcm_pkg::clip_t              out_clip_r;

  always_comb begin
    level = 4'($countones(hs_hit_r));
    g_ch  = tfcm_pkg::LEVEL_ZERO;
    b_ch  = tfcm_pkg::LEVEL_ZERO;
    r_ch  = tfcm_pkg::LEVEL_ZERO;
    case (hs_st_r)
      tfcm_pkg::CLIP_LOW:  b_ch = tfcm_pkg::LEVEL_FULL;
      tfcm_pkg::CLIP_HIGH: r_ch = tfcm_pkg::LEVEL_FULL;
      default: begin
        case (hs_qtr_r)
          tfcm_pkg::QTR_BLUE_GREEN: begin
            b_ch = tfcm_pkg::LEVEL_FULL;
            g_ch = level;
          end
          tfcm_pkg::QTR_GREEN_BLUE: begin
            g_ch = tfcm_pkg::LEVEL_FULL;
            b_ch = level;
          end
          tfcm_pkg::QTR_GREEN_RED: begin
            g_ch = tfcm_pkg::LEVEL_FULL;
            r_ch = level;
          end
          default: begin  // red with fading green
            r_ch = tfcm_pkg::LEVEL_FULL;
            g_ch = level;
          end
        endcase
      end
    endcase
    pixel_nxt = {g_ch, b_ch, alpha_r, r_ch};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= hs_v_r;
    end
  end

  always_ff @(posedge clk) begin
    out_pixel_r <= pixel_nxt;
    out_clip_r  <= hs_st_r;
  end

  assign out_valid       = out_valid_r;
  assign out_pixel       = out_pixel_r;
  assign out_clip_status = out_clip_r;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  logic dv_first_in_range;
  logic dv_last_in_range;

  assign dv_first_in_range = dv_v_r[0] && (dv_st_r[0] == tfcm_pkg::CLIP_NONE);
  assign dv_last_in_range  = dv_v_r[FB] && (dv_st_r[FB] == tfcm_pkg::CLIP_NONE);

  // in-range item entering the divider must satisfy num < den
  `TFCM_ASSERT_IMP(a_num_below_den, dv_first_in_range, dv_rem_r[0] < dv_den_r[0])
  // the remainder never reaches the divisor at the divider's last stage
  `TFCM_ASSERT_IMP(a_rem_below_den, dv_last_in_range, dv_rem_r[FB] < dv_den_r[FB])
  // threshold hits form a thermometer code
  `TFCM_ASSERT_IMP(a_hit_thermo, hs_v_r, (hs_hit_r & (hs_hit_r + 1'b1)) == '0)
  // a delivered status is never the unused code
  `TFCM_ASSERT_IMP(a_status_legal, out_valid, out_clip_status != tfcm_pkg::CLIP_RESERVED)

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the jet false-color map: drives temperature
// samples with random gaps under a series of limit/alpha settings and checks
// every pixel and clip status against a cycle-free predictor of the scale.
// ---------------------------------------------------------------------------
module tb;
  import tfcm_pkg::*;

  localparam int FB        = FRACTION_BITS_DEF;
  localparam int LATENCY   = FB + 4;
  localparam int MAX_CYCLE = 500_000;
  localparam logic [63:0] QSPAN = 64'd1 << (FB - 2);  // width of one quarter of f

  // one expected pixel, with the sample that caused it for the log
  typedef struct {
    temp_t            temp;
    logic [PIXEL_W-1:0] pixel;
    clip_t            clip;
  } pixel_result_t;

  // Predictor of the color scale plus the queue of pixels still in flight.
  class pixel_scoreboard;
    logic signed [TEMP_W-1:0] low_lim;
    logic signed [TEMP_W-1:0] high_lim;
    logic [ALPHA_W-1:0]       alpha;
    pixel_result_t            pending_pixels[$];
    int                       failures;
    int                       n_checked;
    int                       n_low;
    int                       n_high;
    int                       n_mid;

    function new();
      low_lim   = LOW_LIMIT_RST;
      high_lim  = HIGH_LIMIT_RST;
      alpha     = ALPHA_LEVEL_RST;
      failures  = 0;
      n_checked = 0;
      n_low     = 0;
      n_high    = 0;
      n_mid     = 0;
    endfunction

    function void load_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_LOW_LIMIT:   low_lim  = val;
        CFG_HIGH_LIMIT:  high_lim = val;
        CFG_ALPHA_LEVEL: alpha    = val[ALPHA_W-1:0];
        default: ;
      endcase
    endfunction

    // (a*b) >> s on the full 128-bit product
    function logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b, input int s);
      logic [127:0] prod;
      prod = 128'(a) * 128'(b);
      return 64'(prod >> s);
    endfunction

    // Taylor series for sin, Q62 in and out, x in [0, pi/2]
    function logic [63:0] series_sine(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] acc;
      x2   = mul_shr(x, x, 62);
      term = x;
      acc  = x;
      for (int n = 1; n <= 13; n++) begin
        term = mul_shr(term, x2, 62) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) acc = acc - term;
        else acc = acc + term;
      end
      return acc;
    endfunction

    // 15*sin^2(pi*q/2Q) rewritten as 15*(1 + sin(pi*v))/2, v = q/Q - 1/2
    function nibble_t ramp_step(input logic [63:0] q);
      logic [63:0] d;
      logic [63:0] s;
      logic [63:0] acc;
      logic        above;
      if (q == 64'd0) return LEVEL_ZERO;
      if (q >= QSPAN) return LEVEL_FULL;
      above = (q << 1) > QSPAN;
      d     = above ? (q << 1) - QSPAN : QSPAN - (q << 1);
      s     = series_sine(mul_shr(PI_Q62, d, FB - 1));
      if (s > ONE_Q62) s = ONE_Q62;
      s   = s >> 4;
      acc = 64'd15 << 58;
      acc = above ? acc + 64'd15 * s : acc - 64'd15 * s;
      acc = acc >> 59;
      return (acc > 64'd15) ? LEVEL_FULL : acc[3:0];
    endfunction

    function void note_sample(input temp_t raw);
      int            t;
      int            lo;
      int            hi;
      logic [63:0]   f;
      logic [63:0]   p;
      quarter_t      qtr;
      nibble_t       g;
      nibble_t       b;
      nibble_t       r;
      nibble_t       lv;
      pixel_result_t e;
      t = int'($signed(raw));
      lo = int'(low_lim);
      hi = int'(high_lim);
      g = LEVEL_ZERO;
      b = LEVEL_ZERO;
      r = LEVEL_ZERO;
      // low test first, so an empty or inverted window never divides
      if (t <= lo) begin
        b = LEVEL_FULL;
        e.clip = CLIP_LOW;
        n_low++;
      end else if (t >= hi) begin
        r = LEVEL_FULL;
        e.clip = CLIP_HIGH;
        n_high++;
      end else begin
        f   = (64'(t - lo) << FB) / 64'(hi - lo);
        qtr = f[FB-1 -: 2];
        p   = f & (QSPAN - 64'd1);
        lv  = ramp_step(qtr[0] ? QSPAN - p : p);
        case (qtr)
          QTR_BLUE_GREEN: begin b = LEVEL_FULL; g = lv; end
          QTR_GREEN_BLUE: begin g = LEVEL_FULL; b = lv; end
          QTR_GREEN_RED:  begin g = LEVEL_FULL; r = lv; end
          default:        begin r = LEVEL_FULL; g = lv; end
        endcase
        e.clip = CLIP_NONE;
        n_mid++;
      end
      e.temp  = raw;
      e.pixel = {g, b, alpha, r};
      pending_pixels.push_back(e);
    endfunction

    // counts a failure, tells whether it is still worth printing
    function bit log_failure();
      failures++;
      return failures <= 10;
    endfunction

    function void check_pixel(input logic [PIXEL_W-1:0] pix, input clip_t st);
      pixel_result_t e;
      n_checked++;
      if (pending_pixels.size() == 0) begin
        if (log_failure()) $display("unexpected pixel %h status %0d", pix, st);
        return;
      end
      e = pending_pixels.pop_front();
      if (pix !== e.pixel || st !== e.clip) begin
        if (log_failure())
          $display("temp %0d: pixel exp %h got %h, status exp %0d got %0d",
                   $signed(e.temp), e.pixel, pix, e.clip, st);
      end
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction
  endclass

  // ---- DUT signals; the driven inputs are known from time zero ----
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  temp_t                 in_temperature = '0;
  logic                  out_valid;
  logic [PIXEL_W-1:0]    out_pixel;
  clip_t                 out_clip_status;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pixel_scoreboard sb = new();
  int              n_settings = 1;  // reset values count as the first setting
  int              cycles = 0;
  bit              gaps_on;
  int              cur_lo;
  int              cur_hi;

  always #1 clk = ~clk;

  thermal_false_color_map #(.FRACTION_BITS(FB)) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_temperature  (in_temperature),
    .out_valid       (out_valid),
    .out_pixel       (out_pixel),
    .out_clip_status (out_clip_status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // Monitor: everything here reads the values that held just before the
  // edge, which is what the DUT sees at that same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_sample(in_temperature);
      if (out_valid) sb.check_pixel(out_pixel, out_clip_status);
    end
  end

  // Watchdog: generous bound on the slowest legal run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == MAX_CYCLE) begin
      $display("timeout after %0d cycles, %0d pixels still pending", cycles, sb.pending());
      $display("thermal_false_color_map: mismatch");
      $finish;
    end
  end

  // Present one sample and hold it until an edge accepts the transaction.
  // start is left high so back-to-back samples need no extra assignment.
  task automatic send_sample(input int t);
    start          <= 1'b1;
    in_temperature <= temp_t'(t);
    do @(posedge clk); while (busy);
  endtask

  // Mostly no gap, some short ones, a few long ones.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(15, 4);
    return $urandom_range(80, 30);
  endfunction

  task automatic idle_gap();
    int n;
    n = gaps_on ? pick_gap() : 0;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every pixel in flight has been checked.
  // It waits for an edge first, so the monitor has noted the last accepted sample.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // Register writes happen only from an idle block; we stays high across
  // the three writes and drops once at the end.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(posedge clk);
    sb.load_reg(idx, CFG_DATA_W'(val));
  endtask

  task automatic apply_settings(input int lo, input int hi, input int alpha);
    write_reg(CFG_LOW_LIMIT, lo);
    write_reg(CFG_HIGH_LIMIT, hi);
    write_reg(CFG_ALPHA_LEVEL, alpha);
    cfg_we <= 1'b0;
    cur_lo = lo;
    cur_hi = hi;
    n_settings++;
  endtask

  function automatic int clamp16(input int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  // Random window shapes: narrow, medium, nearly full range, empty or
  // inverted, and fully random limits.
  task automatic pick_settings(input int mode, output int lo, output int hi, output int alpha);
    int width;
    case (mode)
      0: begin
        lo = -32768 + int'($urandom_range(65535 - 64));
        hi = lo + 1 + int'($urandom_range(63));
      end
      1: begin
        width = 65 + int'($urandom_range(3935));
        lo    = -32768 + int'($urandom_range(65535 - width));
        hi    = lo + width;
      end
      2: begin
        lo = -32768 + int'($urandom_range(999));
        hi = 32767 - int'($urandom_range(999));
      end
      3: begin
        lo = -32000 + int'($urandom_range(64000));
        hi = lo - int'($urandom_range(200));
      end
      default: begin
        lo = int'($signed(16'($urandom)));
        hi = int'($signed(16'($urandom)));
      end
    endcase
    alpha = $urandom_range(15);
  endtask

  // Mostly samples around the window, some right on its edges, the rest
  // anywhere in the 16-bit range.
  function automatic int pick_temp(input int lo, input int hi);
    int roll;
    int a;
    int z;
    roll = $urandom_range(99);
    if (roll < 20) return int'($signed(16'($urandom)));
    if (roll < 30) begin
      case ($urandom_range(3))
        0: return clamp16(lo);
        1: return clamp16(lo + 1);
        2: return clamp16(hi - 1);
        default: return clamp16(hi);
      endcase
    end
    a = clamp16(((lo < hi) ? lo : hi) - 4);
    z = clamp16(((lo < hi) ? hi : lo) + 4);
    return a + int'($urandom_range(z - a));
  endfunction

  initial begin
    int lo;
    int hi;
    int alpha;
    int leftover;

    cur_lo = -400;
    cur_hi = 1200;
    gaps_on = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset settings (-40.0 .. 120.0, window 1600): both input
    // extremes, the limits themselves, the points next to them, the middle
    // of the first quarter and the three quarter boundaries.
    send_sample(-32768);
    send_sample(32767);
    send_sample(-400);
    send_sample(-399);
    send_sample(-200);
    send_sample(0);
    send_sample(400);
    send_sample(800);
    send_sample(1199);
    send_sample(1200);
    drain();

    // widest window, alpha off: one step above low gives f = 1
    apply_settings(-32768, 32767, 0);
    send_sample(-32767);
    send_sample(-1);
    send_sample(32766);
    drain();

    // inverted window: no division, everything above low is red
    apply_settings(100, -100, 15);
    send_sample(100);
    send_sample(101);
    drain();

    // empty window: both limits met, low wins
    apply_settings(500, 500, 15);
    send_sample(500);
    send_sample(501);
    drain();

    // window of two: the only in-range sample sits at f = one half
    apply_settings(0, 2, 3);
    send_sample(1);
    drain();

    // Random phases; each starts from an idle block and ends with a full
    // drain, two of them run without any idle cycles.
    for (int ph = 0; ph < 8; ph++) begin
      pick_settings(ph % 5, lo, hi, alpha);
      apply_settings(lo, hi, alpha);
      gaps_on = (ph != 3 && ph != 6);
      for (int i = 0; i < 250; i++) begin
        send_sample(pick_temp(cur_lo, cur_hi));
        idle_gap();
      end
      drain();
    end

    // catch any stray strobe after the last expected pixel
    repeat (LATENCY + 8) @(posedge clk);

    leftover = sb.pending();
    if (leftover > 0) begin
      sb.failures++;
      $display("%0d expected pixels never arrived", leftover);
    end
    $display("covered %0d pixels over %0d register settings", sb.n_checked, n_settings);
    $display("  %0d in range, %0d clipped low, %0d clipped high, %0d failures",
             sb.n_mid, sb.n_low, sb.n_high, sb.failures);
    if (sb.failures == 0) begin
      $display("thermal_false_color_map: match");
    end else begin
      $display("thermal_false_color_map: mismatch");
    end
    $finish;
  end

endmodule
